>>> design/bpfa_pkg.sv
package bpfa_pkg;

	localparam int ADDR_W     = 32;
	localparam int COUNT_W    = 13;
	localparam int RES_W      = 24;

	localparam int NUM_PAGES  = 4096;
	localparam int FRAME_SIZE = 4096;
	localparam int WORD_BITS  = 64;

	localparam int MAP_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PAGE_SHIFT = $clog2(FRAME_SIZE);
	localparam int PAGE_W     = $clog2(NUM_PAGES + 1);
	localparam int SUM_W      = $clog2(NUM_PAGES + 2 ** COUNT_W);

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_RESERVE = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		WOP_FIND  = 2'd0,
		WOP_SET   = 2'd1,
		WOP_CLEAR = 2'd2
	} wop_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_ALLOC = 2'd1,
		S_RANGE = 2'd2,
		S_DONE  = 2'd3
	} state_t;

	typedef struct packed {
		wop_t             op;
		logic [BIT_W-1:0] lo;
		logic [BIT_W:0]   hi;
	} word_op_t;

endpackage

>>> design/bpfa_word_unit.sv
module bpfa_word_unit (
	input  bpfa_pkg::word_op_t                 wop,
	input  logic [bpfa_pkg::WORD_BITS-1:0]     word,
	output logic [bpfa_pkg::WORD_BITS-1:0]     new_word,
	output logic                               hit,
	output logic [bpfa_pkg::BIT_W-1:0]         bit_idx
);

	logic [bpfa_pkg::WORD_BITS-1:0] run_mask;
	logic [bpfa_pkg::WORD_BITS-1:0] ones;

	assign ones     = {bpfa_pkg::WORD_BITS{1'b1}};
	assign run_mask = (ones << wop.lo) & ~(ones << wop.hi);

	// lowest set bit
	always_comb begin
		bit_idx = '0;
		for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (word[i]) begin
				bit_idx = bpfa_pkg::BIT_W'(i);
			end
		end
	end

	always_comb begin
		hit      = 1'b0;
		new_word = word;
		case (wop.op)
			bpfa_pkg::WOP_FIND: begin
				hit      = |word;
				new_word = word & ~(bpfa_pkg::WORD_BITS'(1) << bit_idx);
			end
			bpfa_pkg::WOP_SET: begin
				new_word = word | run_mask;
			end
			bpfa_pkg::WOP_CLEAR: begin
				new_word = word & ~run_mask;
			end
			default: begin
				new_word = word;
			end
		endcase
	end

endmodule

>>> design/bitmap_page_frame_allocator_unit.sv
// Page frame allocator over a bitmap of NUM_PAGES bits (set = free) held in a single
// MAP_WORDS x WORD_BITS memory with one read and one write port, empty after reset
// (per-word valid flops, so no clearing pass). One request is worked at a time by
// a word update unit that takes one word per cycle through a read-modify-write
// stream: allocate scans from word 0 and stops at the first word with a free
// page, or runs through all MAP_WORDS words when the map is full; free, reserve
// and release walk only the words the run touches; an empty run or a start
// beyond the map skips the scan and goes straight to the result.
// A finished result waits in an output register, and a new request is taken as
// soon as the sequencer is back in idle, which it enters at the same clock edge
// that loads the result.
module bitmap_page_frame_allocator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       cmd,
	input  logic [bpfa_pkg::ADDR_W-1:0]      address,
	input  logic [bpfa_pkg::COUNT_W-1:0]     page_count,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bpfa_pkg::RES_W-1:0]       result_address,
	output logic [1:0]                       status
);

	localparam int WB = bpfa_pkg::WORD_BITS;
	localparam int BW = bpfa_pkg::BIT_W;
	localparam int XW = bpfa_pkg::WIDX_W;
	localparam int PW = bpfa_pkg::PAGE_W;
	localparam int SW = bpfa_pkg::SUM_W;
	localparam int AW = bpfa_pkg::ADDR_W;
	localparam int RW = bpfa_pkg::RES_W;

	bpfa_pkg::state_t   state_q, state_d;

	logic [WB-1:0]      map_mem [bpfa_pkg::MAP_WORDS];
	logic [bpfa_pkg::MAP_WORDS-1:0] valid_q;

	logic [XW-1:0]      ptr_q, last_q, sw_q, ew_q;
	logic               issue_q;
	logic [BW-1:0]      slo_q;
	logic [BW:0]        ehi_q;
	logic               set_q;
	logic               rd_v_s1;
	logic [XW-1:0]      widx_s1;
	logic [WB-1:0]      rdata_s1;

	logic [RW-1:0]      pend_res_q, result_q;
	bpfa_pkg::status_t  pend_st_q, status_q;
	logic               out_valid_q;

	// request decode
	bpfa_pkg::cmd_t     cmd_in;
	logic [AW-1:0]      page_full;
	logic               in_store;
	logic [PW-1:0]      s_page;
	logic [SW-1:0]      cnt_eff, sum_pg;
	logic               over;
	logic [PW-1:0]      e_page, e_m1;
	logic               run_empty;
	logic [RW-1:0]      acc_res;
	bpfa_pkg::status_t  acc_st;

	// sequencer strobes
	logic               accept, working, fin, rd_en, wr_en, load_out;

	bpfa_pkg::word_op_t wop;
	logic [WB-1:0]      word_eff, new_word;
	logic               hit;
	logic [BW-1:0]      bit_idx;
	logic [RW-1:0]      alloc_addr;

	assign cmd_in    = bpfa_pkg::cmd_t'(cmd);
	assign page_full = address >> bpfa_pkg::PAGE_SHIFT;
	assign in_store  = page_full < AW'(bpfa_pkg::NUM_PAGES);
	assign s_page    = PW'(page_full);
	assign cnt_eff   = (cmd_in == bpfa_pkg::CMD_FREE) ? SW'(1) : SW'(page_count);
	assign sum_pg    = SW'(s_page) + cnt_eff;
	assign over      = sum_pg > SW'(bpfa_pkg::NUM_PAGES);
	assign e_page    = over ? PW'(bpfa_pkg::NUM_PAGES) : PW'(sum_pg);
	assign e_m1      = e_page - PW'(1);
	assign run_empty = !in_store || (cnt_eff == '0);

	always_comb begin
		acc_res = '0;
		acc_st  = bpfa_pkg::ST_OK;
		case (cmd_in)
			bpfa_pkg::CMD_ALLOC: begin
				acc_res = '0;
				acc_st  = bpfa_pkg::ST_OK;
			end
			bpfa_pkg::CMD_FREE: begin
				acc_res = '0;
				acc_st  = in_store ? bpfa_pkg::ST_OK : bpfa_pkg::ST_RANGE;
			end
			default: begin
				acc_res = RW'(address);
				acc_st  = (!in_store || over) ? bpfa_pkg::ST_RANGE : bpfa_pkg::ST_OK;
			end
		endcase
	end

	// shared word unit
	assign word_eff = valid_q[widx_s1] ? rdata_s1 : '0;

	always_comb begin
		wop.op = (state_q == bpfa_pkg::S_ALLOC) ? bpfa_pkg::WOP_FIND :
		         (set_q ? bpfa_pkg::WOP_SET : bpfa_pkg::WOP_CLEAR);
		wop.lo = (widx_s1 == sw_q) ? slo_q : '0;
		wop.hi = (widx_s1 == ew_q) ? ehi_q : (BW + 1)'(WB);
	end

	bpfa_word_unit u_word (
		.wop      (wop),
		.word     (word_eff),
		.new_word (new_word),
		.hit      (hit),
		.bit_idx  (bit_idx)
	);

	assign alloc_addr = RW'({widx_s1, bit_idx, bpfa_pkg::PAGE_SHIFT'(0)});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpfa_pkg::S_IDLE: begin
				if (in_valid) begin
					if (cmd_in == bpfa_pkg::CMD_ALLOC) begin
						state_d = bpfa_pkg::S_ALLOC;
					end else if (run_empty) begin
						state_d = bpfa_pkg::S_DONE;
					end else begin
						state_d = bpfa_pkg::S_RANGE;
					end
				end
			end
			bpfa_pkg::S_ALLOC, bpfa_pkg::S_RANGE: begin
				if (fin) begin
					state_d = bpfa_pkg::S_DONE;
				end
			end
			bpfa_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpfa_pkg::S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		working  = (state_q == bpfa_pkg::S_ALLOC) || (state_q == bpfa_pkg::S_RANGE);
		accept   = in_valid && (state_q == bpfa_pkg::S_IDLE);
		fin      = rd_v_s1 && ((widx_s1 == last_q) ||
		           ((state_q == bpfa_pkg::S_ALLOC) && hit));
		rd_en    = working && issue_q && !fin;
		wr_en    = rd_v_s1 && ((state_q == bpfa_pkg::S_RANGE) || hit);
		load_out = (state_q == bpfa_pkg::S_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpfa_pkg::S_IDLE;
			issue_q     <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			if (accept) begin
				issue_q <= 1'b1;
			end else if (rd_en) begin
				issue_q <= (ptr_q != last_q);
			end
			if (wr_en) begin
				valid_q[widx_s1] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sw_q       <= XW'(s_page >> BW);
			ew_q       <= XW'(e_m1 >> BW);
			slo_q      <= s_page[BW-1:0];
			ehi_q      <= {1'b0, e_m1[BW-1:0]} + (BW + 1)'(1);
			set_q      <= (cmd_in == bpfa_pkg::CMD_FREE) || (cmd_in == bpfa_pkg::CMD_RELEASE);
			pend_res_q <= acc_res;
			pend_st_q  <= acc_st;
			if (cmd_in == bpfa_pkg::CMD_ALLOC) begin
				ptr_q  <= '0;
				last_q <= XW'(bpfa_pkg::MAP_WORDS - 1);
			end else begin
				ptr_q  <= XW'(s_page >> BW);
				last_q <= XW'(e_m1 >> BW);
			end
		end else begin
			if (rd_en) begin
				ptr_q <= ptr_q + XW'(1);
			end
			if (fin && (state_q == bpfa_pkg::S_ALLOC)) begin
				pend_res_q <= hit ? alloc_addr : '0;
				pend_st_q  <= hit ? bpfa_pkg::ST_OK : bpfa_pkg::ST_EMPTY;
			end
		end
		if (rd_en) begin
			widx_s1 <= ptr_q;
		end
		if (load_out) begin
			result_q <= pend_res_q;
			status_q <= pend_st_q;
		end
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= map_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[widx_s1] <= new_word;
		end
	end

	assign in_stall       = (state_q != bpfa_pkg::S_IDLE);
	assign out_valid      = out_valid_q;
	assign result_address = result_q;
	assign status         = status_q;

	a_wr_while_working: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> working)
		else $error("map write outside a scan");

	a_read_while_working: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> working)
		else $error("read data outside a scan");

	a_hit_ends_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bpfa_pkg::S_ALLOC && rd_v_s1 && hit) |=> state_q == bpfa_pkg::S_DONE)
		else $error("allocate continued past a free page");

	a_empty_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != bpfa_pkg::ST_EMPTY || result_address == '0))
		else $error("no-free-page result with nonzero address");

endmodule
